>>> hw/rtl/gsva_pkg.sv
// gsva_pkg: shared widths, reset values and lane control type for the
// group soft-vote argmax block. No dependencies.
`default_nettype none

package gsva_pkg;

	// Field and accumulator widths
	localparam int PROB_W         = 16;
	localparam int SUM_W          = 32;
	localparam int NUM_LABELS_W   = 4;
	localparam int DEF_MAX_LABELS = 8;

	// num_labels after reset
	localparam logic [NUM_LABELS_W-1:0] NUM_LABELS_RST = 4'd8;

	// Per-lane control from the top level to one accumulator lane
	typedef struct packed {
		logic acc;     // non-empty row accepted this cycle
		logic last;    // that row closes the group
		logic active;  // lane is lane 0 or below num_labels
	} lane_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/group_soft_vote_argmax.sv
// group_soft_vote_argmax: soft-voting argmax over groups of probability rows.
// Depends on gsva_pkg, gsva_lane and gsva_argmax.
//
// Usage:
//  - Slave stream carries one row per transaction: tdata holds the per-label
//    Q1.15 probabilities, tlast marks the group's last row, tuser flags an
//    empty group (emits label 0 at once, running sums untouched).
//  - Each lane below num_labels adds its probability into a saturating
//    32-bit sum in the cycle the row is taken; one row per cycle
//    sustained while s_tready is high.
//  - A last row (or empty group) sends the updated sums into a registered
//    compare tree; the master stream then carries the winning label and
//    the sticky saturation flag from the last tree level's registers.
//    Non-last rows give no result.
//  - The config channel writes num_labels (always ready); write it only
//    while the block is idle. 0 acts as 1, values above MAX_LABELS as
//    MAX_LABELS.
//  - Reset clears all sums, the saturation flag and the pipeline, and sets
//    num_labels to 8.
//  - When the master side stalls, results fill the tree stages behind the
//    output register; s_tready drops only once every stage is full.
`default_nettype none

module group_soft_vote_argmax
	import gsva_pkg::*;
#(
	parameter int MAX_LABELS = DEF_MAX_LABELS,
	localparam int LW = $clog2(MAX_LABELS),
	localparam int OW = ((LW + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// tdata: prob_0 .. prob_N, 16 bits each, prob_0 lowest
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [MAX_LABELS*PROB_W-1:0] s_tdata,
	input  logic                         s_tlast,   // last_row
	input  logic                         s_tuser,   // empty_group
	// tdata: label, zero padded to whole bytes
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [OW-1:0]                m_tdata,
	output logic                         m_tuser,   // saturated
	// num_labels register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [NUM_LABELS_W-1:0]      cfg_data
);

	localparam int CW = NUM_LABELS_W + 1;

	logic [NUM_LABELS_W-1:0]      num_labels_q;
	logic                         sat_q;
	logic                         acc;
	logic                         res_valid;
	logic                         row_hit;
	logic                         res_sat;
	logic [MAX_LABELS-1:0]        lane_act;
	logic [MAX_LABELS-1:0]        lane_hit;
	logic [MAX_LABELS-1:0]        res_mask;
	logic [MAX_LABELS-1:0][SUM_W-1:0] lane_sum;
	logic [LW-1:0]                label;

	// Config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_labels_q <= NUM_LABELS_RST;
		end else if (cfg_valid && cfg_ready) begin
			num_labels_q <= cfg_data;
		end
	end

	// Row control
	assign acc       = s_tvalid && s_tready && !s_tuser;
	assign res_valid = s_tvalid && (s_tlast || s_tuser);

	// Accumulator lanes; lane 0 is always in use
	generate
		for (genvar i = 0; i < MAX_LABELS; i++) begin : g_lane
			lane_ctl_t ctl;

			assign lane_act[i] = (i == 0) || (CW'(i) < CW'(num_labels_q));
			assign ctl.acc     = acc;
			assign ctl.last    = s_tlast;
			assign ctl.active  = lane_act[i];

			gsva_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.prob    (s_tdata[i*PROB_W +: PROB_W]),
				.sum_upd (lane_sum[i]),
				.hit     (lane_hit[i])
			);
		end
	endgenerate

	assign row_hit = |lane_hit;

	// Sticky saturation flag, cleared at group end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (acc) begin
			sat_q <= s_tlast ? 1'b0 : (sat_q | row_hit);
		end
	end

	// Empty group: only lane 0 competes, flag reported clear
	assign res_mask = s_tuser ? MAX_LABELS'(1) : lane_act;
	assign res_sat  = !s_tuser && (sat_q || row_hit);

	gsva_argmax #(
		.MAX_LABELS (MAX_LABELS)
	) u_argmax (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (s_tready),
		.in_sums   (lane_sum),
		.in_mask   (res_mask),
		.in_sat    (res_sat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_idx   (label),
		.out_sat   (m_tuser)
	);

	assign m_tdata = OW'(label);

	// Group end leaves the flag clear
	a_sat_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tlast) |=> !sat_q)
		else $error("saturation flag not cleared after last row");

	// Flag only rises on an accepted row
	a_sat_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sat_q) |-> $past(acc))
		else $error("saturation flag set without a row");

	// A ready sink never backs up the source
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

endmodule

`default_nettype wire

>>> hw/rtl/gsva_lane.sv
// gsva_lane: one label's saturating 32-bit running sum.
// Depends on gsva_pkg.
`default_nettype none

module gsva_lane
	import gsva_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lane_ctl_t         ctl,
	input  logic [PROB_W-1:0] prob,
	output logic [SUM_W-1:0]  sum_upd,  // sum including this row
	output logic              hit       // this row hit the ceiling
);

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0]   add_w;
	logic             carry;
	logic [SUM_W-1:0] sat_sum;

	// Saturating add; reaching all ones with a nonzero addend also counts
	assign add_w   = {1'b0, sum_q} + (SUM_W+1)'(prob);
	assign carry   = add_w[SUM_W];
	assign sat_sum = carry ? '1 : add_w[SUM_W-1:0];
	assign sum_upd = ctl.active ? sat_sum : sum_q;
	assign hit     = ctl.active & (carry | ((&add_w[SUM_W-1:0]) & (|prob)));

	// Accumulate; cleared once the group's last row has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= ctl.last ? '0 : sum_upd;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/gsva_argmax.sv
// gsva_argmax: registered compare tree that merges the lane sums into the
// index of the largest one (lowest index on ties). Depends on gsva_pkg.
`default_nettype none

module gsva_argmax
	import gsva_pkg::*;
#(
	parameter int MAX_LABELS = DEF_MAX_LABELS,
	localparam int IW = $clog2(MAX_LABELS)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [MAX_LABELS-1:0][SUM_W-1:0] in_sums,
	input  logic [MAX_LABELS-1:0]            in_mask,
	input  logic                             in_sat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [IW-1:0]                    out_idx,
	output logic                             out_sat
);

	localparam int LV = IW;
	localparam int P  = 2 ** LV;

	// Stage arrays: first index is the tree level, stage 0 holds the sums
	logic             v_s   [0:LV];
	logic             sat_s [0:LV];
	logic [SUM_W-1:0] val_s [0:LV][0:P-1];
	logic [IW-1:0]    idx_s [0:LV][0:P-1];
	logic             vld_s [0:LV][0:P-1];
	logic             adv   [0:LV];

	// A stage moves when it is empty or the next one moves
	generate
		for (genvar l = 0; l <= LV; l++) begin : g_adv
			if (l == LV) begin : g_end
				assign adv[l] = !v_s[l] || out_ready;
			end else begin : g_mid
				assign adv[l] = !v_s[l] || adv[l+1];
			end
		end
	endgenerate

	assign in_ready = adv[0];

	// Stage 0 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && in_valid) begin
			sat_s[0] <= in_sat;
		end
	end

	// Stage 0 leaves; padding leaves never win
	generate
		for (genvar j = 0; j < P; j++) begin : g_leaf
			always_ff @(posedge clk) begin
				if (adv[0] && in_valid) begin
					idx_s[0][j] <= IW'(j);
					if (j < MAX_LABELS) begin
						val_s[0][j] <= in_sums[j];
						vld_s[0][j] <= in_mask[j];
					end else begin
						val_s[0][j] <= '0;
						vld_s[0][j] <= 1'b0;
					end
				end
			end
		end
	endgenerate

	// Tree levels: a valid right child wins when the left is invalid or smaller
	generate
		for (genvar l = 1; l <= LV; l++) begin : g_lvl
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[l] <= 1'b0;
				end else if (adv[l]) begin
					v_s[l] <= v_s[l-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv[l] && v_s[l-1]) begin
					sat_s[l] <= sat_s[l-1];
				end
			end

			for (genvar j = 0; j < (P >> l); j++) begin : g_node
				logic take_r;

				assign take_r = vld_s[l-1][2*j+1] &&
				                (!vld_s[l-1][2*j] ||
				                 (val_s[l-1][2*j+1] > val_s[l-1][2*j]));

				always_ff @(posedge clk) begin
					if (adv[l] && v_s[l-1]) begin
						val_s[l][j] <= take_r ? val_s[l-1][2*j+1] : val_s[l-1][2*j];
						idx_s[l][j] <= take_r ? idx_s[l-1][2*j+1] : idx_s[l-1][2*j];
						vld_s[l][j] <= vld_s[l-1][2*j+1] | vld_s[l-1][2*j];
					end
				end
			end
		end
	endgenerate

	assign out_valid = v_s[LV];
	assign out_idx   = idx_s[LV][0];
	assign out_sat   = sat_s[LV];

endmodule

`default_nettype wire

>>> dv/group_soft_vote_argmax_tb.sv
// group_soft_vote_argmax_tb: self-checking testbench for the soft-vote argmax block.
// Depends on gsva_pkg and group_soft_vote_argmax; drives rows with bursty gaps and a
// stalling receiver; checks each label against in-bench running-sum or pinned votes.

module group_soft_vote_argmax_tb;
	import gsva_pkg::*;

	localparam int     LANES          = DEF_MAX_LABELS;
	localparam int     LABEL_W        = $clog2(LANES);
	localparam int     OUT_W          = ((LABEL_W + 7) / 8) * 8;
	localparam int     PIPE_LAT       = 1 + LABEL_W;
	localparam int     SETTLE_CYCLES  = 2 * PIPE_LAT + 4;
	localparam int     CLK_PERIOD     = 12;
	localparam longint LIMIT_CYCLES   = 1000000;
	localparam int     PHASES         = 10;
	localparam int     ROWS_PER_PHASE = 175;
	localparam int     NONE           = -1;
	localparam int     NDIR           = 27;
	localparam int     REPORT_MAX     = 10;

	typedef logic [PROB_W-1:0] prob_t;

	typedef struct packed {
		prob_t [LANES-1:0] prob;
		logic              last;
		logic              empty;
	} row_t;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               sat;
	} vote_t;

	typedef enum logic {OP_ROW, OP_CFG} op_t;

	// One directed step: lane values come from an even/odd fill plus up to two hot lanes
	typedef struct {
		op_t op;
		int  even_v;
		int  odd_v;
		int  hot_a;
		int  val_a;
		int  hot_b;
		int  val_b;
		bit  last;
		bit  empty;
		int  cfg;
		bit  pinned;
		int  label;
		bit  sat;
	} step_t;

	step_t directed_plan [NDIR] = '{
		'{OP_ROW, 'hFFFF, 'hFFFF, NONE, 0,       NONE, 0,    1, 1, 0,  1, 0, 0},
		'{OP_ROW, 0,      0,      NONE, 0,       NONE, 0,    1, 0, 0,  1, 0, 0},
		'{OP_ROW, 0,      0,      7,    32768,   NONE, 0,    1, 0, 0,  1, 7, 0},
		'{OP_ROW, 'hFFFF, 'hFFFF, NONE, 0,       NONE, 0,    1, 0, 0,  1, 0, 0},
		'{OP_ROW, 32768,  32768,  3,    'hFFFF,  NONE, 0,    1, 0, 0,  1, 3, 0},
		'{OP_ROW, 'hAAAA, 'h5555, NONE, 0,       NONE, 0,    1, 0, 0,  0, 0, 0},
		'{OP_ROW, 'h5555, 'hAAAA, NONE, 0,       NONE, 0,    1, 0, 0,  0, 0, 0},
		'{OP_ROW, 0,      0,      1,    500,     6,    500,  1, 0, 0,  1, 1, 0},
		'{OP_ROW, 0,      0,      2,    100,     NONE, 0,    0, 0, 0,  0, 0, 0},
		'{OP_ROW, 1,      1,      NONE, 0,       NONE, 0,    0, 1, 0,  1, 0, 0},
		'{OP_ROW, 0,      0,      5,    200,     NONE, 0,    1, 0, 0,  0, 0, 0},
		'{OP_CFG, 0,      0,      NONE, 0,       NONE, 0,    0, 0, 1,  0, 0, 0},
		'{OP_ROW, 0,      0,      0,    5,       1,    9000, 1, 0, 0,  1, 0, 0},
		'{OP_CFG, 0,      0,      NONE, 0,       NONE, 0,    0, 0, 0,  0, 0, 0},
		'{OP_ROW, 0,      0,      4,    32768,   NONE, 0,    1, 0, 0,  1, 0, 0},
		'{OP_CFG, 0,      0,      NONE, 0,       NONE, 0,    0, 0, 15, 0, 0, 0},
		'{OP_ROW, 0,      0,      7,    1,       NONE, 0,    1, 0, 0,  1, 7, 0},
		'{OP_CFG, 0,      0,      NONE, 0,       NONE, 0,    0, 0, 3,  0, 0, 0},
		'{OP_ROW, 0,      0,      2,    3,       NONE, 0,    0, 0, 0,  0, 0, 0},
		'{OP_CFG, 0,      0,      NONE, 0,       NONE, 0,    0, 0, 8,  0, 0, 0},
		'{OP_ROW, 0,      0,      5,    1000,    NONE, 0,    0, 0, 0,  0, 0, 0},
		'{OP_CFG, 0,      0,      NONE, 0,       NONE, 0,    0, 0, 2,  0, 0, 0},
		'{OP_ROW, 0,      0,      1,    1,       NONE, 0,    1, 0, 0,  0, 0, 0},
		'{OP_CFG, 0,      0,      NONE, 0,       NONE, 0,    0, 0, 8,  0, 0, 0},
		'{OP_ROW, 0,      0,      5,    1,       NONE, 0,    1, 0, 0,  0, 0, 0},
		'{OP_CFG, 0,      0,      NONE, 0,       NONE, 0,    0, 0, 9,  0, 0, 0},
		'{OP_ROW, 0,      0,      7,    2,       NONE, 0,    1, 0, 0,  1, 7, 0}
	};

	int phase_labels [8] = '{8, 1, 15, 0, 4, 9, 2, 7};

	// DUT signals, all known from time zero
	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [LANES*PROB_W-1:0]  s_tdata   = '0;     // prob_0 .. prob_7, prob_0 lowest
	logic                     s_tlast   = 1'b0;   // last_row
	logic                     s_tuser   = 1'b0;   // empty_group
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [OUT_W-1:0]         m_tdata;            // label, zero padded
	logic                     m_tuser;            // saturated
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [NUM_LABELS_W-1:0]  cfg_data  = '0;

	// Predictor state
	logic [SUM_W-1:0]        vote_sums [LANES];
	logic                    sums_saturated;
	logic [NUM_LABELS_W-1:0] num_labels_q;
	vote_t                   pending_votes [$];

	// Bookkeeping
	int mismatches     = 0;
	int rows_sent      = 0;
	int votes_checked  = 0;
	int votes_sat      = 0;
	int cfg_writes     = 0;
	int burst_left     = 0;
	int gap_max        = 6;
	int ready_left     = 0;
	int stall_left     = 0;

	group_soft_vote_argmax DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run limit, far above the slowest legal run
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("group_soft_vote_argmax_tb: errors");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("MISMATCH @%0t: %s", $realtime, what);
	endtask

	// Accumulate one row; returns 1 when the row yields a label
	function automatic bit tally_row(input row_t r, output vote_t v);
		int unsigned      used;
		int               best;
		logic [SUM_W:0]   wide;
		v = '0;
		if (r.empty)
			return 1'b1;
		if (num_labels_q == 0)
			used = 1;
		else if (num_labels_q > LANES)
			used = LANES;
		else
			used = num_labels_q;
		for (int k = 0; k < used; k++) begin
			wide = {1'b0, vote_sums[k]} + r.prob[k];
			if (wide[SUM_W]) begin
				vote_sums[k]   = '1;
				sums_saturated = 1'b1;
			end else begin
				vote_sums[k] = wide[SUM_W-1:0];
				if (&vote_sums[k] && r.prob[k] != 0)
					sums_saturated = 1'b1;
			end
		end
		if (!r.last)
			return 1'b0;
		// strict compare keeps the lowest index on ties
		best = 0;
		for (int k = 1; k < used; k++)
			if (vote_sums[k] > vote_sums[best])
				best = k;
		v.label = best[LABEL_W-1:0];
		v.sat   = sums_saturated;
		for (int k = 0; k < LANES; k++)
			vote_sums[k] = '0;
		sums_saturated = 1'b0;
		return 1'b1;
	endfunction

	// Drive one row with bursty gaps; the prediction is made when the transaction lands
	task automatic send_row(input row_t r, input bit pinned, input vote_t pinned_vote);
		int    gap;
		vote_t v;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(1, 8);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= r.prob;
		s_tlast  <= r.last;
		s_tuser  <= r.empty;
		do @(posedge clk); while (!s_tready);
		rows_sent++;
		if (tally_row(r, v))
			pending_votes.push_back(pinned ? pinned_vote : v);
	endtask

	// Drain outstanding labels, let the pipeline empty, then write num_labels
	task automatic load_num_labels(input logic [NUM_LABELS_W-1:0] value);
		s_tvalid  <= 1'b0;
		burst_left = 0;
		while (pending_votes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		num_labels_q = value;
		cfg_writes++;
	endtask

	// Receiver: alternating ready runs and stalls of random length
	always @(posedge clk) begin
		if (ready_left > 0) begin
			m_tready <= 1'b1;
			ready_left--;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready  <= 1'b1;
			ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(0, 10);
			stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		end
	end

	// Result checker: each output transaction against the oldest prediction
	always @(posedge clk) begin
		vote_t want;
		if (arst_n && m_tvalid && m_tready) begin
			votes_checked++;
			if (m_tuser)
				votes_sat++;
			if (pending_votes.size() == 0) begin
				flag_mismatch($sformatf("unexpected label %0d sat %0b", m_tdata, m_tuser));
			end else begin
				want = pending_votes.pop_front();
				if (m_tdata !== OUT_W'(want.label) || m_tuser !== want.sat)
					flag_mismatch($sformatf("label exp %0d got %0d, sat exp %0b got %0b",
						want.label, m_tdata, want.sat, m_tuser));
			end
		end
	end

	// Stimulus: directed table, then random phases
	initial begin
		step_t step;
		row_t  row;
		vote_t fixed_vote;
		int    lane_val;
		int    group_left;
		int    mode;
		int    pick;

		group_left = 0;
		for (int k = 0; k < LANES; k++)
			vote_sums[k] = '0;
		sums_saturated = 1'b0;
		num_labels_q   = NUM_LABELS_RST;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed steps
		for (int i = 0; i < NDIR; i++) begin
			step = directed_plan[i];
			if (step.op == OP_CFG) begin
				load_num_labels(step.cfg[NUM_LABELS_W-1:0]);
			end else begin
				for (int k = 0; k < LANES; k++) begin
					lane_val = (k % 2 == 0) ? step.even_v : step.odd_v;
					if (k == step.hot_a)
						lane_val = step.val_a;
					if (k == step.hot_b)
						lane_val = step.val_b;
					row.prob[k] = prob_t'(lane_val);
				end
				row.last         = step.last;
				row.empty        = step.empty;
				fixed_vote.label = step.label[LABEL_W-1:0];
				fixed_vote.sat   = step.sat;
				send_row(row, step.pinned, fixed_vote);
			end
		end

		// Random phases; groups may stay open across a num_labels change
		for (int p = 0; p < PHASES; p++) begin
			load_num_labels((p < 8) ? NUM_LABELS_W'(phase_labels[p])
			                        : NUM_LABELS_W'($urandom_range(0, 15)));
			for (int n = 0; n < ROWS_PER_PHASE; n++) begin
				row  = '0;
				mode = $urandom_range(0, 9);
				if ($urandom_range(0, 15) == 0) begin
					row.empty = 1'b1;
					row.last  = $urandom_range(0, 1);
				end else begin
					if (group_left == 0) begin
						pick       = $urandom_range(0, 19);
						group_left = (pick < 14) ? $urandom_range(1, 4)
						           : (pick < 19) ? $urandom_range(5, 12)
						                         : $urandom_range(13, 40);
					end
					group_left--;
					row.last = (group_left == 0);
				end
				for (int k = 0; k < LANES; k++) begin
					if (mode < 5)
						row.prob[k] = prob_t'($urandom_range(0, 32768));
					else if (mode < 7)
						row.prob[k] = prob_t'($urandom);
					else if (mode < 9)
						row.prob[k] = prob_t'(16384 * $urandom_range(0, 2));
					else
						row.prob[k] = prob_t'($urandom_range(0, 3));
				end
				send_row(row, 1'b0, '0);
			end
		end

		// Drain and settle
		s_tvalid <= 1'b0;
		while (pending_votes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_votes.size() != 0)
			flag_mismatch($sformatf("%0d labels never arrived", pending_votes.size()));

		$display("summary: %0d rows sent, %0d labels checked (%0d saturated), %0d mismatches",
			rows_sent, votes_checked, votes_sat, mismatches);
		$display("summary: %0d num_labels writes incl. 0, 15 and mid-group changes",
			cfg_writes);
		if (mismatches == 0)
			$display("group_soft_vote_argmax_tb: clean");
		else
			$display("group_soft_vote_argmax_tb: errors");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/gsva_pkg.sv
hw/rtl/gsva_lane.sv
hw/rtl/gsva_argmax.sv
hw/rtl/group_soft_vote_argmax.sv
dv/group_soft_vote_argmax_tb.sv
